// ===== rtl/core/spfc_pkg.sv =====
package spfc_pkg;

	localparam int unsigned VALUE_MAX_BYTES = 4;
	localparam int unsigned VALUE_WORD_BYTES = 4;

	localparam logic [7:0]  HEAD1_BYTE = 8'hAA;
	localparam logic [7:0]  HEAD2_BYTE = 8'h55;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;

	localparam logic [2:0] VALUE_BYTES_RESET = 3'd4;

	typedef enum logic [2:0] {
		PH_HEAD1 = 3'd0,
		PH_HEAD2 = 3'd1,
		PH_ID    = 3'd2,
		PH_TYPE  = 3'd3,
		PH_VALUE = 3'd4,
		PH_CHECK = 3'd5
	} phase_t;

	typedef struct packed {
		logic        status;
		logic [7:0]  device_id;
		logic [7:0]  data_type;
		logic [31:0] value_bits;
	} result_t;

	function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/spfc_crc.sv =====
module spfc_crc import spfc_pkg::*; (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);

	assign crc_out = crc16_update(crc_in, data);

endmodule

// ===== rtl/core/spfc_parser.sv =====
module spfc_parser import spfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data,
	input  logic [2:0]  value_bytes,
	output logic        res_fire,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic [15:0] crc_q, crc_d;
	logic [31:0] word_q, word_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [7:0]  id_q, id_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  chk_hi_q, chk_hi_d;
	logic        chk_second_q, chk_second_d;
	logic [15:0] crc_next;
	logic [2:0]  frame_len;

	spfc_crc u_crc (
		.crc_in  (crc_q),
		.data    (data),
		.crc_out (crc_next)
	);

	always_comb begin
		frame_len = value_bytes;
		if (frame_len == 3'd0) begin
			frame_len = 3'd1;
		end
		if (frame_len > 3'(VALUE_MAX_BYTES)) begin
			frame_len = 3'(VALUE_MAX_BYTES);
		end
	end

	always_comb begin
		phase_d      = PH_HEAD1;
		crc_d        = CRC_INIT;
		word_d       = '0;
		cnt_d        = '0;
		id_d         = '0;
		type_d       = '0;
		chk_hi_d     = '0;
		chk_second_d = 1'b0;
		unique case (phase_q)
			PH_HEAD1: begin
				if (data == HEAD1_BYTE) begin
					phase_d = PH_HEAD2;
				end
			end
			PH_HEAD2: begin
				if (data == HEAD2_BYTE) begin
					phase_d = PH_ID;
				end
			end
			PH_ID: begin
				if (data != HEAD1_BYTE) begin
					phase_d = PH_TYPE;
					id_d    = data;
					crc_d   = crc_next;
				end
			end
			PH_TYPE: begin
				if (data != HEAD1_BYTE) begin
					phase_d = PH_VALUE;
					id_d    = id_q;
					type_d  = data;
					crc_d   = crc_next;
				end
			end
			PH_VALUE: begin
				id_d   = id_q;
				type_d = type_q;
				crc_d  = crc_next;
				word_d = word_q;
				if (cnt_q < 3'(VALUE_WORD_BYTES)) begin
					unique case (cnt_q[1:0])
						2'd0: word_d[31:24] = data;
						2'd1: word_d[23:16] = data;
						2'd2: word_d[15:8]  = data;
						2'd3: word_d[7:0]   = data;
					endcase
				end
				if (({1'b0, cnt_q} + 4'd1) >= {1'b0, frame_len}) begin
					phase_d = PH_CHECK;
					cnt_d   = '0;
				end else begin
					phase_d = PH_VALUE;
					cnt_d   = cnt_q + 3'd1;
				end
			end
			PH_CHECK: begin
				if (!chk_second_q) begin
					phase_d      = PH_CHECK;
					id_d         = id_q;
					type_d       = type_q;
					crc_d        = crc_q;
					word_d       = word_q;
					chk_hi_d     = data;
					chk_second_d = 1'b1;
				end
			end
			default: begin
				phase_d = PH_HEAD1;
			end
		endcase
	end

	always_comb begin
		res_fire       = (phase_q == PH_CHECK) && chk_second_q;
		res.status     = ({chk_hi_q, data} != crc_q);
		res.device_id  = id_q;
		res.data_type  = type_q;
		res.value_bits = word_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEAD1;
			crc_q        <= CRC_INIT;
			word_q       <= '0;
			cnt_q        <= '0;
			id_q         <= '0;
			type_q       <= '0;
			chk_hi_q     <= '0;
			chk_second_q <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			crc_q        <= crc_d;
			word_q       <= word_d;
			cnt_q        <= cnt_d;
			id_q         <= id_d;
			type_q       <= type_d;
			chk_hi_q     <= chk_hi_d;
			chk_second_q <= chk_second_d;
		end
	end

endmodule

// ===== rtl/core/spfc_out_reg.sv =====
module spfc_out_reg import spfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  result_t     res,
	output logic        free,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [7:0]  device_id,
	output logic [7:0]  data_type,
	output logic [31:0] value_bits
);

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_q <= res;
		end
	end

	assign out_valid  = valid_q;
	assign status     = res_q.status;
	assign device_id  = res_q.device_id;
	assign data_type  = res_q.data_type;
	assign value_bits = res_q.value_bits;

endmodule

// ===== rtl/core/sensor_frame_parser_crc16.sv =====
// Second check byte: input register, then output register loads its result, setting out_valid.
// Throughput: one byte per cycle; the input register and output register keep bytes moving
// while a finished result waits, stalling only when a new result meets a full output register.
// Reset: arst_n clears all control state asynchronously, returns the parser to header hunt
// and sets value_bytes to 4.
module sensor_frame_parser_crc16 import spfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [7:0]  device_id,
	output logic [7:0]  data_type,
	output logic [31:0] value_bits
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [2:0] value_bytes_q;
	logic       advance;
	logic       res_fire;
	logic       out_free;
	result_t    res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_bytes_q <= VALUE_BYTES_RESET;
		end else if (cfg_we) begin
			value_bytes_q <= cfg_wdata;
		end
	end

	// hold a result-producing byte until the output register can take it
	assign advance  = valid_s1 && (!res_fire || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	spfc_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.data        (byte_s1),
		.value_bytes (value_bytes_q),
		.res_fire    (res_fire),
		.res         (res)
	);

	spfc_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && res_fire),
		.res        (res),
		.free       (out_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.device_id  (device_id),
		.data_type  (data_type),
		.value_bits (value_bits)
	);

endmodule

// ===== sim/tb_sensor_frame_parser_crc16.sv =====
module tb_sensor_frame_parser_crc16;
	timeunit 1ns;
	timeprecision 1ps;

	import spfc_pkg::*;

	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned QUIET_LIMIT   = 3000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned TAIL_CYCLES   = 10;
	localparam int unsigned PHASE_BYTES   = 190;
	localparam int unsigned NUM_PHASES    = 8;

	typedef enum logic [2:0] {
		ROW_BYTE,
		ROW_CHECK_HI,
		ROW_CHECK_HI_BAD,
		ROW_CHECK_LO,
		ROW_SET_LEN
	} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [7:0] data;
		bit typed;
		result_t want;
	} stim_row_t;

	localparam result_t NO_RESULT = '0;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_ready;
	logic        status;
	logic [7:0]  device_id;
	logic [7:0]  data_type;
	logic [31:0] value_bits;

	sensor_frame_parser_crc16 dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.device_id  (device_id),
		.data_type  (data_type),
		.value_bits (value_bits)
	);

	// parser state mirrored from the stream of accepted bytes
	phase_t      ph;
	logic [15:0] crc_run;
	logic [31:0] word_acc;
	logic [2:0]  val_cnt;
	logic [7:0]  id_hold;
	logic [7:0]  type_hold;
	logic [15:0] chk_acc;
	bit          chk_hi_done;
	logic [2:0]  len_reg;

	result_t     pending_frames[$];
	int unsigned mismatch_count = 0;
	int unsigned payload_bytes = 0;
	int unsigned idle_pct = 20;
	bit          hold_req = 0;

	localparam logic [2:0] PHASE_LEN [NUM_PHASES] = '{3'd1, 3'd7, 3'd2, 3'd0,
		3'd3, 3'd6, 3'd5, 3'd4};
	localparam int unsigned PHASE_IDLE [NUM_PHASES] = '{20, 0, 40, 10, 25, 5, 15, 0};

	stim_row_t plan [33] = '{
		'{ROW_BYTE, 8'hAA, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'hAA, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'hAA, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'h55, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'hAA, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'hAA, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'h55, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'hFF, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'hAA, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'hFF, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'hAA, 1'b0, NO_RESULT},
		'{ROW_CHECK_HI, 8'h00, 1'b0, NO_RESULT},
		'{ROW_CHECK_LO, 8'h00, 1'b1, '{1'b0, 8'hFF, 8'h00, 32'hAAFF00AA}},
		'{ROW_SET_LEN, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'hAA, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'h55, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'h01, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'h02, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'h7F, 1'b0, NO_RESULT},
		'{ROW_CHECK_HI_BAD, 8'h00, 1'b0, NO_RESULT},
		'{ROW_CHECK_LO, 8'h00, 1'b1, '{1'b1, 8'h01, 8'h02, 32'h7F000000}},
		'{ROW_SET_LEN, 8'h07, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'hAA, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'h55, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'h03, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'h04, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'h11, 1'b0, NO_RESULT},
		'{ROW_SET_LEN, 8'h01, 1'b0, NO_RESULT},
		'{ROW_BYTE, 8'h22, 1'b0, NO_RESULT},
		'{ROW_CHECK_HI, 8'h00, 1'b0, NO_RESULT},
		'{ROW_CHECK_LO, 8'h00, 1'b1, '{1'b0, 8'h03, 8'h04, 32'h11220000}}
	};

	function automatic logic [15:0] crc_after(input logic [15:0] c_in, input logic [7:0] d);
		logic [15:0] c;
		bit fb;
		c = c_in ^ {8'h00, d};
		for (int i = 0; i < 8; i++) begin
			fb = c[0];
			c = c >> 1;
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	function automatic int unsigned len_in_force();
		if (len_reg == 3'd0)
			return 1;
		if (len_reg > VALUE_MAX_BYTES)
			return VALUE_MAX_BYTES;
		return len_reg;
	endfunction

	function automatic logic [7:0] any_but_head();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == HEAD1_BYTE);
		return b;
	endfunction

	task automatic hunt_reset();
		ph = PH_HEAD1;
		crc_run = CRC_INIT;
		word_acc = '0;
		val_cnt = '0;
		id_hold = '0;
		type_hold = '0;
		chk_acc = '0;
		chk_hi_done = 1'b0;
	endtask

	task automatic parse_byte(input logic [7:0] b, output bit got, output result_t r);
		got = 1'b0;
		r = NO_RESULT;
		case (ph)
			PH_HEAD1: begin
				if (b == HEAD1_BYTE)
					ph = PH_HEAD2;
				else
					hunt_reset();
			end
			PH_HEAD2: begin
				if (b == HEAD2_BYTE)
					ph = PH_ID;
				else
					hunt_reset();
			end
			PH_ID: begin
				if (b == HEAD1_BYTE) begin
					hunt_reset();
				end else begin
					id_hold = b;
					crc_run = crc_after(crc_run, b);
					ph = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (b == HEAD1_BYTE) begin
					hunt_reset();
				end else begin
					type_hold = b;
					crc_run = crc_after(crc_run, b);
					ph = PH_VALUE;
				end
			end
			PH_VALUE: begin
				if (val_cnt < VALUE_WORD_BYTES)
					word_acc = word_acc | (32'(b) << (24 - 8 * int'(val_cnt)));
				crc_run = crc_after(crc_run, b);
				if (int'(val_cnt) + 1 >= len_in_force()) begin
					val_cnt = '0;
					ph = PH_CHECK;
				end else begin
					val_cnt = val_cnt + 3'd1;
				end
			end
			PH_CHECK: begin
				if (!chk_hi_done) begin
					chk_acc = {8'h00, b};
					chk_hi_done = 1'b1;
				end else begin
					chk_acc = {chk_acc[7:0], b};
					r.status = (chk_acc != crc_run);
					r.device_id = id_hold;
					r.data_type = type_hold;
					r.value_bits = word_acc;
					got = 1'b1;
					hunt_reset();
				end
			end
			default: hunt_reset();
		endcase
	endtask

	task automatic put_byte(input logic [7:0] b, input bit counted = 1'b1,
			input bit typed = 1'b0, input result_t want = NO_RESULT);
		bit got;
		result_t r;
		int unsigned gap;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		// hold the request until accepted
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		parse_byte(b, got, r);
		if (typed)
			pending_frames.push_back(want);
		else if (got)
			pending_frames.push_back(r);
		if (counted)
			payload_bytes++;
	endtask

	task automatic set_len(input logic [2:0] v);
		in_valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		len_reg = v;
	endtask

	task automatic put_noise();
		int unsigned n;
		n = $urandom_range(1, 4);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0)
				put_byte(HEAD1_BYTE, 1'b0);
			else
				put_byte(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	task automatic send_random_frame();
		int unsigned r;
		int unsigned n;
		logic [15:0] chk;
		r = $urandom_range(0, 99);
		put_byte(HEAD1_BYTE);
		put_byte(HEAD2_BYTE);
		if (r < 3) begin
			put_byte(HEAD1_BYTE);
			return;
		end
		put_byte(any_but_head());
		if (r < 6) begin
			put_byte(HEAD1_BYTE);
			return;
		end
		put_byte(any_but_head());
		n = len_in_force();
		repeat (n) begin
			if ($urandom_range(0, 7) == 0)
				put_byte(HEAD1_BYTE);
			else
				put_byte(8'($urandom_range(0, 255)));
		end
		if (r < 9)
			return;
		chk = crc_run;
		if (r < 35)
			chk = chk ^ (16'd1 << $urandom_range(0, 15));
		put_byte(chk[15:8]);
		put_byte(chk[7:0]);
	endtask

	task automatic check_frame();
		result_t want;
		if (pending_frames.size() == 0) begin
			$display("%0t: frame expected none, got status %0b id %02h type %02h value %08h",
				$time, status, device_id, data_type, value_bits);
			mismatch_count++;
			return;
		end
		want = pending_frames.pop_front();
		if (status !== want.status) begin
			$display("%0t: status expected %0b, got %0b", $time, want.status, status);
			mismatch_count++;
		end
		if (device_id !== want.device_id) begin
			$display("%0t: device_id expected %02h, got %02h", $time, want.device_id,
				device_id);
			mismatch_count++;
		end
		if (data_type !== want.data_type) begin
			$display("%0t: data_type expected %02h, got %02h", $time, want.data_type,
				data_type);
			mismatch_count++;
		end
		if (value_bits !== want.value_bits) begin
			$display("%0t: value_bits expected %08h, got %08h", $time, want.value_bits,
				value_bits);
			mismatch_count++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int unsigned stall_left;
		int unsigned hold_left;
		stall_left = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(negedge clk);
			if (out_valid && out_ready)
				check_frame();
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(1, 12) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(negedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("** sensor_frame_parser_crc16: FAILED **");
		$finish;
	end

	initial begin
		logic [7:0] b;
		int unsigned target;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		in_byte <= '0;
		len_reg = VALUE_BYTES_RESET;
		hunt_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_CHECK_HI:     b = crc_run[15:8];
				ROW_CHECK_HI_BAD: b = crc_run[15:8] ^ 8'h01;
				ROW_CHECK_LO:     b = crc_run[7:0];
				default:          b = plan[i].data;
			endcase
			if (plan[i].kind == ROW_SET_LEN)
				set_len(plan[i].data[2:0]);
			else
				put_byte(b, 1'b1, plan[i].typed, plan[i].want);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_len(PHASE_LEN[p]);
			idle_pct = PHASE_IDLE[p];
			if (p == 2)
				hold_req = 1'b1;
			target = payload_bytes + PHASE_BYTES;
			while (payload_bytes < target) begin
				if ($urandom_range(0, 99) < 15)
					put_noise();
				send_random_frame();
			end
			// leave a frame open across the next length change
			if (p != NUM_PHASES - 1 && $urandom_range(0, 1) == 1) begin
				put_byte(HEAD1_BYTE);
				put_byte(HEAD2_BYTE);
				put_byte(any_but_head());
				put_byte(any_but_head());
				put_byte(8'($urandom_range(0, 255)));
			end
		end

		in_valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("** sensor_frame_parser_crc16: PASSED **");
		else
			$display("** sensor_frame_parser_crc16: FAILED **");
		$finish;
	end

endmodule

// ===== sensor_frame_parser_crc16.f =====
rtl/core/spfc_pkg.sv
rtl/core/spfc_crc.sv
rtl/core/spfc_parser.sv
rtl/core/spfc_out_reg.sv
rtl/core/sensor_frame_parser_crc16.sv
sim/tb_sensor_frame_parser_crc16.sv
